@@ design/bze_pkg.sv @@
// Shared types, codes and constants of the bitmap zoom expander.
// Used by every module of the block but bze_ram; depends on nothing.
package bze_pkg;

  localparam int unsigned MAX_SRC_WIDTH_DEF  = 512;
  localparam int unsigned MAX_SRC_HEIGHT_DEF = 512;
  localparam int unsigned MAX_OUT_WIDTH_DEF  = 2048;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QLW    = $clog2(QDEPTH + 1);

  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 40;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [CFG_IW-1:0] REG_ZOOM_STEP  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_X_ORIGIN   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_Y_ORIGIN   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SRC_WIDTH  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SRC_HEIGHT = 3'd4;
  localparam logic [CFG_IW-1:0] REG_OUT_WIDTH  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_FG_COLOR   = 3'd6;
  localparam logic [CFG_IW-1:0] REG_OR_MODE    = 3'd7;

  localparam logic [39:0] ONE_FX     = 40'h01_0000_0000;
  localparam logic [7:0]  LEFT_BIT   = 8'h80;

  typedef struct packed {
    logic [39:0] zoom_step;
    logic [16:0] x_origin;
    logic [16:0] y_origin;
    logic [9:0]  src_width;
    logic [9:0]  src_height;
    logic [11:0] out_width;
    logic [31:0] fg_color;
    logic        or_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    zoom_step:  ONE_FX,
    x_origin:   17'd0,
    y_origin:   17'd0,
    src_width:  10'd512,
    src_height: 10'd512,
    out_width:  12'd640,
    fg_color:   32'hFFFF_FFFF,
    or_mode:    1'b0
  };

  typedef struct packed {
    logic set;
    logic last;
  } pix_t;

endpackage

@@ design/bitmap_zoom_expander.sv @@
// Top level of the 1bpp bitmap nearest-neighbor zoom expander.
// Holds the configuration registers; depends on bze_pkg, bze_front, bze_queue, bze_back.
//
//   channel  direction  handshake                word
//   in       input      in_valid_i / in_stall_o  op, src_row, src_byte_index, src_byte
//   out      output     out_valid_o / out_stall_i pixel, write_enable, line_end
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One word per clock in both directions while neither side stalls; a pixel tick's
// result passes the store read, the queue and the output register in that order.
// Reset clears the counters, accumulators and configuration; the bitmap store
// has no clearing pass and holds garbage until loaded.
// The input stalls once the queue and the store read stage hold four results.
module bitmap_zoom_expander #(
  parameter int unsigned MAX_SRC_WIDTH  = bze_pkg::MAX_SRC_WIDTH_DEF,
  parameter int unsigned MAX_SRC_HEIGHT = bze_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int unsigned MAX_OUT_WIDTH  = bze_pkg::MAX_OUT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 op_i,
  input  logic [8:0]                 src_row_i,
  input  logic [5:0]                 src_byte_index_i,
  input  logic [7:0]                 src_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [31:0]                pixel_o,
  output logic                       write_enable_o,
  output logic                       line_end_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bze_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [bze_pkg::CFG_DW-1:0] cfg_data_i
);

  bze_pkg::cfg_t           cfg_q;
  logic                    push;
  bze_pkg::pix_t           push_data;
  logic                    pop;
  bze_pkg::pix_t           q_head;
  logic [bze_pkg::QLW-1:0] q_level;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bze_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bze_pkg::REG_ZOOM_STEP:  cfg_q.zoom_step  <= cfg_data_i;
        bze_pkg::REG_X_ORIGIN:   cfg_q.x_origin   <= cfg_data_i[16:0];
        bze_pkg::REG_Y_ORIGIN:   cfg_q.y_origin   <= cfg_data_i[16:0];
        bze_pkg::REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data_i[9:0];
        bze_pkg::REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data_i[9:0];
        bze_pkg::REG_OUT_WIDTH:  cfg_q.out_width  <= cfg_data_i[11:0];
        bze_pkg::REG_FG_COLOR:   cfg_q.fg_color   <= cfg_data_i[31:0];
        bze_pkg::REG_OR_MODE:    cfg_q.or_mode    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  bze_front #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .MAX_OUT_WIDTH  (MAX_OUT_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .src_row_i        (src_row_i),
    .src_byte_index_i (src_byte_index_i),
    .src_byte_i       (src_byte_i),
    .q_level_i        (q_level),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  bze_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (q_head),
    .level_o     (q_level)
  );

  bze_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_level_i      (q_level),
    .q_head_i       (q_head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_o        (pixel_o),
    .write_enable_o (write_enable_o),
    .line_end_o     (line_end_o)
  );

endmodule

@@ design/bze_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module bze_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32768,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bze_front.sv @@
// Front end: accepts words, loads the bitmap store, steps the zoom accumulators
// and looks up source bits. Depends on bze_pkg and bze_ram.
module bze_front #(
  parameter int unsigned MAX_SRC_WIDTH  = bze_pkg::MAX_SRC_WIDTH_DEF,
  parameter int unsigned MAX_SRC_HEIGHT = bze_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int unsigned MAX_OUT_WIDTH  = bze_pkg::MAX_OUT_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bze_pkg::cfg_t           cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              op_i,
  input  logic [8:0]              src_row_i,
  input  logic [5:0]              src_byte_index_i,
  input  logic [7:0]              src_byte_i,
  input  logic [bze_pkg::QLW-1:0] q_level_i,
  output logic                    push_o,
  output bze_pkg::pix_t           push_data_o
);

  localparam int unsigned ROW_BYTES = (MAX_SRC_WIDTH + 7) / 8;
  localparam int unsigned STORE     = MAX_SRC_HEIGHT * ROW_BYTES;
  localparam int unsigned AW        = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int unsigned XW        = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned YW        = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
  localparam int unsigned CW        = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

  logic [63:0]   col_accum_q, col_accum_d;
  logic [63:0]   row_accum_q, row_accum_d;
  logic [CW-1:0] col_count_q, col_count_d;

  logic          s1_valid_q;
  logic          s1_inside_q;
  logic [2:0]    s1_bit_q;
  logic          s1_last_q;

  logic          accept;
  logic          tick;
  logic          load_en;
  logic [AW-1:0] load_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [7:0]    shifted;

  logic [31:0]   w_eff;
  logic [31:0]   h_eff;
  logic [31:0]   ow_eff;
  logic [33:0]   rx;
  logic [33:0]   ry;
  logic          in_range;
  logic          last;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [31:0]   addr_full;
  logic [31:0]   load_full;

  assign in_stall_o = (32'(q_level_i) + 32'(s1_valid_q)) >= 32'(bze_pkg::QDEPTH);
  assign accept     = in_valid_i && !in_stall_o;
  assign tick       = accept && (op_i == bze_pkg::OP_TICK);

  assign load_en = accept && (op_i == bze_pkg::OP_LOAD)
                && (32'(src_row_i) < 32'(MAX_SRC_HEIGHT))
                && (32'(src_byte_index_i) < 32'(ROW_BYTES));
  assign load_full = 32'(src_row_i) * 32'(ROW_BYTES) + 32'(src_byte_index_i);
  assign load_addr = load_full[AW-1:0];

  assign w_eff  = (32'(cfg_i.src_width) > 32'(MAX_SRC_WIDTH))
                ? 32'(MAX_SRC_WIDTH) : 32'(cfg_i.src_width);
  assign h_eff  = (32'(cfg_i.src_height) > 32'(MAX_SRC_HEIGHT))
                ? 32'(MAX_SRC_HEIGHT) : 32'(cfg_i.src_height);
  assign ow_eff = (cfg_i.out_width == 12'd0) ? 32'd1
                : (32'(cfg_i.out_width) > 32'(MAX_OUT_WIDTH))
                ? 32'(MAX_OUT_WIDTH) : 32'(cfg_i.out_width);

  assign rx = {{17{cfg_i.x_origin[16]}}, cfg_i.x_origin} + {2'b00, col_accum_q[63:32]};
  assign ry = {{17{cfg_i.y_origin[16]}}, cfg_i.y_origin} + {2'b00, row_accum_q[63:32]};

  assign in_range = !rx[33] && !ry[33]
                 && (rx < {2'b00, w_eff}) && (ry < {2'b00, h_eff});
  assign cx = rx[XW-1:0];
  assign cy = ry[YW-1:0];
  assign addr_full = 32'(cy) * 32'(ROW_BYTES) + 32'(cx >> 3);
  assign rd_addr   = addr_full[AW-1:0];

  assign last = (32'(col_count_q) + 32'd1) >= ow_eff;

  always_comb begin
    col_accum_d = col_accum_q;
    row_accum_d = row_accum_q;
    col_count_d = col_count_q;
    if (accept) begin
      unique case (op_i)
        bze_pkg::OP_TICK: begin
          if (last) begin
            col_count_d = '0;
            col_accum_d = '0;
            row_accum_d = row_accum_q + 64'(cfg_i.zoom_step);
          end else begin
            col_count_d = col_count_q + CW'(1);
            col_accum_d = col_accum_q + 64'(cfg_i.zoom_step);
          end
        end
        bze_pkg::OP_RESTART: begin
          col_count_d = '0;
          col_accum_d = '0;
          row_accum_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_accum_q <= '0;
      row_accum_q <= '0;
      col_count_q <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      col_accum_q <= col_accum_d;
      row_accum_q <= row_accum_d;
      col_count_q <= col_count_d;
      s1_valid_q  <= tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      s1_inside_q <= in_range;
      s1_bit_q    <= cx[2:0];
      s1_last_q   <= last;
    end
  end

  bze_ram #(
    .WIDTH (8),
    .DEPTH (STORE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_en),
    .waddr_i (load_addr),
    .wdata_i (src_byte_i),
    .re_i    (tick && in_range),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign shifted = rd_data << s1_bit_q;

  assign push_o           = s1_valid_q;
  assign push_data_o.set  = s1_inside_q && ((shifted & bze_pkg::LEFT_BIT) != 8'd0);
  assign push_data_o.last = s1_last_q;

endmodule

@@ design/bze_queue.sv @@
// Short FIFO of looked-up pixels between front and back end.
// Depends on bze_pkg.
module bze_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  bze_pkg::pix_t           push_data_i,
  input  logic                    pop_i,
  output bze_pkg::pix_t           head_o,
  output logic [bze_pkg::QLW-1:0] level_o
);

  bze_pkg::pix_t entries_q [bze_pkg::QDEPTH];
  logic [bze_pkg::QPW-1:0] wr_q;
  logic [bze_pkg::QPW-1:0] rd_q;
  logic [bze_pkg::QLW-1:0] level_q, level_d;

  always_comb begin
    level_d = level_q;
    if (push_i && !pop_i) begin
      level_d = level_q + bze_pkg::QLW'(1);
    end else if (!push_i && pop_i) begin
      level_d = level_q - bze_pkg::QLW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      level_q <= level_d;
      if (push_i) begin
        wr_q <= wr_q + bze_pkg::QPW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + bze_pkg::QPW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= push_data_i;
    end
  end

  assign head_o  = entries_q[rd_q];
  assign level_o = level_q;

endmodule

@@ design/bze_back.sv @@
// Back end: turns queued source bits into colored output words in a
// registered output stage. Depends on bze_pkg.
module bze_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bze_pkg::cfg_t           cfg_i,
  input  logic [bze_pkg::QLW-1:0] q_level_i,
  input  bze_pkg::pix_t           q_head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [31:0]             pixel_o,
  output logic                    write_enable_o,
  output logic                    line_end_o
);

  logic        out_valid_q;
  logic [31:0] pixel_q;
  logic        write_enable_q;
  logic        line_end_q;

  assign pop_o = (q_level_i != '0) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pixel_q        <= q_head_i.set ? cfg_i.fg_color : 32'd0;
      write_enable_q <= q_head_i.set || !cfg_i.or_mode;
      line_end_q     <= q_head_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_o        = pixel_q;
  assign write_enable_o = write_enable_q;
  assign line_end_o     = line_end_q;

endmodule

@@ tb/sv/bze_checker.sv @@
// Scoreboard for the bitmap zoom expander: mirrors the registers, the bitmap store
// and the raster position, predicts one pixel word per tick and checks the output.
// Depends on bze_pkg.
module bze_checker
  import bze_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        op_i,
  input  logic [8:0]        src_row_i,
  input  logic [5:0]        src_byte_index_i,
  input  logic [7:0]        src_byte_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [31:0]       pixel_i,
  input  logic              write_enable_i,
  input  logic              line_end_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  output int                mismatches_o,
  output int                pending_o
);

  localparam int ROW_BYTES   = (MAX_SRC_WIDTH_DEF + 7) / 8;
  localparam int STORE_DEPTH = ROW_BYTES * MAX_SRC_HEIGHT_DEF;

  typedef struct packed {
    logic [31:0] pixel;
    logic        write_enable;
    logic        line_end;
  } pixel_word_t;

  logic [7:0]  bitmap [0:STORE_DEPTH-1];
  cfg_t        regs = CFG_RESET;
  logic [10:0] col_count = '0;
  logic [63:0] col_acc = '0;
  logic [63:0] row_acc = '0;
  pixel_word_t expected_pixels [$];
  int          mismatch_total = 0;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin : track
    pixel_word_t want;
    pixel_word_t got;
    longint      src_x;
    longint      src_y;
    int          eff_w;
    int          eff_h;
    int          eff_ow;
    logic        hit;
    if (!rst_ni) begin
      regs      = CFG_RESET;
      col_count = '0;
      col_acc   = '0;
      row_acc   = '0;
      expected_pixels.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{pixel: pixel_i, write_enable: write_enable_i, line_end: line_end_i};
        if (expected_pixels.size() == 0) begin
          if (mismatch_total < 10)
            $display("unexpected pixel word: pixel %h we %b line_end %b",
                     got.pixel, got.write_enable, got.line_end);
          mismatch_total++;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            if (mismatch_total < 10)
              $display("pixel word mismatch: expected pixel %h we %b line_end %b, got pixel %h we %b line_end %b",
                       want.pixel, want.write_enable, want.line_end,
                       got.pixel, got.write_enable, got.line_end);
            mismatch_total++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ZOOM_STEP:  regs.zoom_step  = cfg_data_i[39:0];
          REG_X_ORIGIN:   regs.x_origin   = cfg_data_i[16:0];
          REG_Y_ORIGIN:   regs.y_origin   = cfg_data_i[16:0];
          REG_SRC_WIDTH:  regs.src_width  = cfg_data_i[9:0];
          REG_SRC_HEIGHT: regs.src_height = cfg_data_i[9:0];
          REG_OUT_WIDTH:  regs.out_width  = cfg_data_i[11:0];
          REG_FG_COLOR:   regs.fg_color   = cfg_data_i[31:0];
          REG_OR_MODE:    regs.or_mode    = cfg_data_i[0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        case (op_i)
          OP_LOAD: bitmap[int'(src_row_i) * ROW_BYTES + int'(src_byte_index_i)] = src_byte_i;
          OP_RESTART: begin
            col_count = '0;
            col_acc   = '0;
            row_acc   = '0;
          end
          OP_TICK: begin
            eff_w = (regs.src_width > MAX_SRC_WIDTH_DEF) ? MAX_SRC_WIDTH_DEF
                                                         : int'(regs.src_width);
            eff_h = (regs.src_height > MAX_SRC_HEIGHT_DEF) ? MAX_SRC_HEIGHT_DEF
                                                           : int'(regs.src_height);
            if (regs.out_width == '0) eff_ow = 1;
            else if (regs.out_width > MAX_OUT_WIDTH_DEF) eff_ow = MAX_OUT_WIDTH_DEF;
            else eff_ow = int'(regs.out_width);
            src_x = $signed({{47{regs.x_origin[16]}}, regs.x_origin})
                  + $signed({32'd0, col_acc[63:32]});
            src_y = $signed({{47{regs.y_origin[16]}}, regs.y_origin})
                  + $signed({32'd0, row_acc[63:32]});
            hit = 1'b0;
            if (src_x >= 0 && src_y >= 0 && src_x < eff_w && src_y < eff_h)
              hit = |(bitmap[src_y * ROW_BYTES + (src_x >> 3)] & (LEFT_BIT >> src_x[2:0]));
            want.pixel        = hit ? regs.fg_color : 32'd0;
            want.write_enable = hit || !regs.or_mode;
            want.line_end     = (int'(col_count) + 1 >= eff_ow);
            expected_pixels.push_back(want);
            if (want.line_end) begin
              col_count = '0;
              col_acc   = '0;
              row_acc   = row_acc + {24'd0, regs.zoom_step};
            end else begin
              col_count = col_count + 11'd1;
              col_acc   = col_acc + {24'd0, regs.zoom_step};
            end
          end
          default: ;
        endcase
      end

      mismatches_o <= mismatch_total;
      pending_o    <= expected_pixels.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Top of the bitmap zoom expander testbench: clock, reset, word stimulus, output
// stall pattern and verdict. Depends on bze_pkg, bze_checker and the block.
module tb;
  import bze_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ROW_BYTES = (MAX_SRC_WIDTH_DEF + 7) / 8;
  localparam int STORE_DEPTH = ROW_BYTES * MAX_SRC_HEIGHT_DEF;
  localparam int ITEM_TARGET = 1900;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_op;
  logic [8:0]        in_row;
  logic [5:0]        in_index;
  logic [7:0]        in_byte;
  logic              out_valid;
  logic              out_stall;
  logic [31:0]       pixel;
  logic              write_enable;
  logic              line_end;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  int                mismatches;
  int                pending;

  bit loaded [0:STORE_DEPTH-1];
  int items_sent = 0;
  int burst_left = 0;
  int gapless_left = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int rg_row_lo, rg_row_hi, rg_byte_lo, rg_byte_hi;

  bitmap_zoom_expander DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .op_i             (in_op),
    .src_row_i        (in_row),
    .src_byte_index_i (in_index),
    .src_byte_i       (in_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .pixel_o          (pixel),
    .write_enable_o   (write_enable),
    .line_end_o       (line_end),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  bze_checker pixel_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .op_i             (in_op),
    .src_row_i        (in_row),
    .src_byte_index_i (in_index),
    .src_byte_i       (in_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .pixel_i          (pixel),
    .write_enable_i   (write_enable),
    .line_end_i       (line_end),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : receiver
    int hold_left;
    int run_left;
    int stall_pct;
    hold_left = 0;
    run_left  = 0;
    stall_pct = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        hold_left = 80;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_left  = $urandom_range(16, 160);
          stall_pct = $urandom_range(0, 3) * 28;
        end
        run_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [8:0] row,
                           input logic [5:0] index, input logic [7:0] data);
    in_valid <= 1'b1;
    in_op    <= op;
    in_row   <= row;
    in_index <= index;
    in_byte  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_LOAD) loaded[int'(row) * ROW_BYTES + int'(index)] = 1'b1;
    if (op != OP_UNUSED) items_sent++;
    if (gapless_left > 0) begin
      gapless_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(10, 60);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] index, input logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Reads only reach rows at or past the row origin and columns at or past the
  // column origin, inside the clamped source size: make sure every byte of that region is loaded.
  task automatic program_frame(input logic [39:0] zoom, input int xo, input int yo,
                               input int sw, input int sh, input int ow,
                               input logic [31:0] color, input logic orm);
    drain();
    write_reg(REG_ZOOM_STEP, zoom);
    write_reg(REG_X_ORIGIN, {23'd0, xo[16:0]});
    write_reg(REG_Y_ORIGIN, {23'd0, yo[16:0]});
    write_reg(REG_SRC_WIDTH, {30'd0, sw[9:0]});
    write_reg(REG_SRC_HEIGHT, {30'd0, sh[9:0]});
    write_reg(REG_OUT_WIDTH, {28'd0, ow[11:0]});
    write_reg(REG_FG_COLOR, {8'd0, color});
    write_reg(REG_OR_MODE, {39'd0, orm});
    cfg_valid <= 1'b0;
    rg_row_lo  = (yo < 0) ? 0 : yo;
    rg_row_hi  = (sh > MAX_SRC_HEIGHT_DEF) ? MAX_SRC_HEIGHT_DEF : sh;
    rg_byte_lo = ((xo < 0) ? 0 : xo) / 8;
    rg_byte_hi = (((sw > MAX_SRC_WIDTH_DEF) ? MAX_SRC_WIDTH_DEF : sw) + 7) / 8;
    for (int r = rg_row_lo; r < rg_row_hi; r++)
      for (int b = rg_byte_lo; b < rg_byte_hi; b++)
        if (!loaded[r * ROW_BYTES + b] || $urandom_range(0, 7) == 0)
          send_word(OP_LOAD, 9'(r), 6'(b), 8'($urandom));
  endtask

  task automatic run_mix(input int count);
    int roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
        send_word(OP_TICK, 9'($urandom), 6'($urandom), 8'($urandom));
      end else if (roll < 86) begin
        if (rg_row_lo < rg_row_hi && rg_byte_lo < rg_byte_hi)
          send_word(OP_LOAD, 9'($urandom_range(rg_row_lo, rg_row_hi - 1)),
                    6'($urandom_range(rg_byte_lo, rg_byte_hi - 1)), 8'($urandom));
        else
          send_word(OP_TICK, 9'($urandom), 6'($urandom), 8'($urandom));
      end else if (roll < 91) begin
        send_word(OP_LOAD, 9'($urandom), 6'($urandom), 8'($urandom));
      end else if (roll < 95) begin
        send_word(OP_RESTART, 9'($urandom), 6'($urandom), 8'($urandom));
      end else begin
        send_word(OP_UNUSED, 9'($urandom), 6'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic [39:0] zoom;
    int xo, yo, sw, sh, ow;
    int phase_no;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_op     = OP_LOAD;
    in_row    = '0;
    in_index  = '0;
    in_byte   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ZOOM_STEP;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: row 0 from column 0, unit zoom
    send_word(OP_LOAD, 9'd0, 6'd0, 8'hA5);
    send_word(OP_LOAD, 9'd0, 6'd1, 8'h00);
    send_word(OP_LOAD, 9'd511, 6'd63, 8'hFF);
    repeat (12) send_word(OP_TICK, 9'd0, 6'd0, 8'd0);
    send_word(OP_UNUSED, 9'd0, 6'd0, 8'h00);
    send_word(OP_RESTART, 9'h1FF, 6'h3F, 8'hFF);
    repeat (3) send_word(OP_TICK, 9'h1FF, 6'h3F, 8'hFF);

    program_frame(40'd1, -65536, 65535, 0, 0, 0, 32'h0000_0000, 1'b1);
    run_mix(16);
    program_frame(40'hFF_FFFF_FFFF, 65535, -65536, 1023, 1023, 4095, 32'hFFFF_FFFF, 1'b0);
    run_mix(24);
    program_frame(40'h07_8000_0000, 0, 440, 1, 1023, 1, $urandom, 1'b0);
    run_mix(50);
    program_frame(ONE_FX, 500, 0, 1023, 2, 24, $urandom, 1'b1);
    run_mix(60);
    program_frame(40'h00_5555_5555, -3, -1, 20, 6, 37, $urandom, 1'b0);
    run_mix(120);

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) zoom = {8'($urandom), 32'($urandom)};
      else if ($urandom_range(0, 2) == 0) zoom = ONE_FX;
      else zoom = {8'($urandom_range(0, 3)), 32'($urandom)};
      if (zoom == '0) zoom = 40'd1;
      xo = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 131071)) - 65536
                                       : int'($urandom_range(0, 60)) - 20;
      yo = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 131071)) - 65536
                                       : int'($urandom_range(0, 30)) - 8;
      case ($urandom_range(0, 7))
        0: begin
          sw = $urandom_range(65, 1023);
          sh = $urandom_range(1, 2);
        end
        1: begin
          sw = $urandom_range(0, 8);
          sh = $urandom_range(0, 40);
        end
        default: begin
          sw = $urandom_range(1, 64);
          sh = $urandom_range(1, 12);
        end
      endcase
      case ($urandom_range(0, 19))
        0: ow = 0;
        1: ow = MAX_OUT_WIDTH_DEF;
        2: ow = 4095;
        3: ow = $urandom_range(0, 4095);
        default: ow = $urandom_range(1, 40);
      endcase
      program_frame(zoom, xo, yo, sw, sh, ow, $urandom, 1'($urandom_range(0, 1)));
      if (phase_no % 5 == 0) begin
        hold_requests++;
        gapless_left = 40;
      end
      run_mix($urandom_range(40, 140));
      phase_no++;
    end

    drain();
    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ bitmap_zoom_expander.f @@
design/bze_pkg.sv
design/bze_ram.sv
design/bze_front.sv
design/bze_queue.sv
design/bze_back.sv
design/bitmap_zoom_expander.sv
tb/sv/bze_checker.sv
tb/sv/tb.sv
